// ===== rtl/core/bqlp_pkg.sv =====
package bqlp_pkg;

    // field and state widths
    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 24;
    localparam int HIST_W         = 32;

    // fixed-point positions
    localparam int COEF_FRAC_BITS = 20;
    localparam int IN_FRAC_BITS   = 15;
    localparam int HIST_FRAC_BITS = 24;
    localparam int IN_ALIGN       = HIST_FRAC_BITS - IN_FRAC_BITS;

    // output gain, held as a positive signed constant
    localparam int OUT_GAIN       = 22767;
    localparam int GAIN_W         = 16;

    // clamped history value spans [-1.0, +1.0] in Q.24
    localparam int CLAMP_W        = HIST_FRAC_BITS + 2;

    // accumulator holds every product sum at scale 2^(24+COEF_FRAC_BITS)
    localparam int ACC_W          = COEF_W + HIST_W + 3;
    localparam int YW_W           = ACC_W - COEF_FRAC_BITS;

    // configuration port
    localparam int REG_IDX_W      = 3;
    localparam int CFG_DATA_W     = COEF_W;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [HIST_W-1:0]   t_hist;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_B0     = 3'd0,
        REG_B1     = 3'd1,
        REG_B2     = 3'd2,
        REG_A1     = 3'd3,
        REG_A2     = 3'd4,
        REG_BYPASS = 3'd5
    } t_reg_idx;

    typedef struct packed {
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
        logic  bypass;
    } t_coef_set;

    // 1600 Hz, Q 0.8 lowpass at 44.1 kHz
    localparam t_coef RST_B0 = COEF_W'(11885);
    localparam t_coef RST_B1 = COEF_W'(23770);
    localparam t_coef RST_B2 = COEF_W'(11885);
    localparam t_coef RST_A1 = COEF_W'(-1790057);
    localparam t_coef RST_A2 = COEF_W'(789029);

endpackage

// ===== rtl/core/bqlp_if.sv =====
interface bqlp_in_if;
    logic             valid;
    logic             ready;
    bqlp_pkg::t_sample sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqlp_out_if;
    logic             valid;
    logic             ready;
    bqlp_pkg::t_sample sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface bqlp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bqlp_pkg::REG_IDX_W-1:0]      index;
    logic [bqlp_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/bqlp_tap_sum.sv =====
module bqlp_tap_sum (
    input  bqlp_pkg::t_coef_set i_coef,
    input  bqlp_pkg::t_sample   i_x,
    input  bqlp_pkg::t_sample   i_x1,
    input  bqlp_pkg::t_sample   i_x2,
    input  bqlp_pkg::t_hist     i_y1,
    input  bqlp_pkg::t_hist     i_y2,
    output bqlp_pkg::t_hist     o_y
);
    import bqlp_pkg::*;

    logic signed [COEF_W+SAMPLE_W-1:0] p_b0, p_b1, p_b2;
    logic signed [COEF_W+HIST_W-1:0]   p_a1, p_a2;
    logic signed [ACC_W-1:0]           ff_sum;
    logic signed [ACC_W-1:0]           acc;
    logic signed [YW_W-1:0]            y_wide;
    logic                              fits;

    assign p_b0 = i_coef.b0 * i_x;
    assign p_b1 = i_coef.b1 * i_x1;
    assign p_b2 = i_coef.b2 * i_x2;
    assign p_a1 = i_coef.a1 * i_y1;
    assign p_a2 = i_coef.a2 * i_y2;

    assign ff_sum = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2);
    assign acc    = (ff_sum <<< IN_ALIGN) - ACC_W'(p_a1) - ACC_W'(p_a2);

    // dropping the low bits of a two's complement value floors it
    assign y_wide = acc[ACC_W-1:COEF_FRAC_BITS];

    // fits in 32 bits when all bits above the sign bit match it
    assign fits = (y_wide[YW_W-1:HIST_W-1] == '0) || (y_wide[YW_W-1:HIST_W-1] == '1);

    always_comb begin
        if (fits) begin
            o_y = y_wide[HIST_W-1:0];
        end else if (y_wide[YW_W-1]) begin
            o_y = {1'b1, {(HIST_W-1){1'b0}}};
        end else begin
            o_y = {1'b0, {(HIST_W-1){1'b1}}};
        end
    end

endmodule

// ===== rtl/core/bqlp_out_scale.sv =====
module bqlp_out_scale (
    input  bqlp_pkg::t_hist   i_y,
    output bqlp_pkg::t_sample o_sample
);
    import bqlp_pkg::*;

    localparam t_hist Y_ONE     = HIST_W'(1 << HIST_FRAC_BITS);
    localparam t_hist Y_NEG_ONE = -Y_ONE;
    localparam logic signed [GAIN_W-1:0] GAIN = GAIN_W'(OUT_GAIN);
    localparam logic signed [CLAMP_W+GAIN_W-1:0] TRUNC_BIAS =
        (CLAMP_W+GAIN_W)'((1 << HIST_FRAC_BITS) - 1);

    logic signed [CLAMP_W-1:0]        clamped;
    logic signed [CLAMP_W+GAIN_W-1:0] prod;
    logic signed [CLAMP_W+GAIN_W-1:0] prod_adj;

    always_comb begin
        if (i_y > Y_ONE) begin
            clamped = Y_ONE[CLAMP_W-1:0];
        end else if (i_y < Y_NEG_ONE) begin
            clamped = Y_NEG_ONE[CLAMP_W-1:0];
        end else begin
            clamped = i_y[CLAMP_W-1:0];
        end
    end

    assign prod = clamped * GAIN;

    // bias negative values so the shift truncates toward zero
    assign prod_adj = prod[CLAMP_W+GAIN_W-1] ? (prod + TRUNC_BIAS) : prod;

    assign o_sample = prod_adj[HIST_FRAC_BITS+SAMPLE_W-1:HIST_FRAC_BITS];

endmodule

// ===== rtl/core/biquad_lowpass_filter_top.sv =====
// Direct-form-I biquad on signed 16-bit audio: one sample in, one sample out.
// y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2 with coefficients in signed Q3.20
// (already divided by a0), the input read as sample/32768, and y kept in
// signed Q7.24 history, floored and saturated to 32 bits but not clamped.
// The emitted sample clamps y to +/-1.0, scales it by 22767 and truncates
// toward zero. With bypass set, samples pass through unchanged and the
// history is frozen. Coefficients reset to a 1600 Hz, Q 0.8 lowpass at
// 44.1 kHz and are written through the config channel (index 0..4 = b0, b1,
// b2, a1, a2; index 5 = bypass in bit 0; other indexes are ignored); the
// user must write them only while the filter is idle, which the block does
// not enforce. Throughput is one sample per clock while the output is not
// stalled: the five tap products and their sum settle combinationally from
// the input register into the history registers, so the recursion closes
// without adding a stall. A sample passes in order through the input
// register, tap sum register and output scale register. Each stage moves
// when the one after it is empty or moving, so a new transaction can be
// taken while a finished result still waits at the output, if a stage is free.
module biquad_lowpass_filter_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bqlp_in_if.sink        i_in,
    bqlp_out_if.source     o_out,
    bqlp_cfg_if.sink       i_cfg
);
    import bqlp_pkg::*;

    // coefficient registers
    t_coef_set r_coef;

    // filter history
    t_sample   r_x1, r_x2;
    t_hist     r_y1, r_y2;

    // stage a: input register
    logic      r_a_vld;
    t_sample   r_a_x;

    // stage b: tap sum register
    logic      r_b_vld;
    logic      r_b_byp;
    t_sample   r_b_x;
    t_hist     r_b_y;

    // stage o: output register
    logic      r_o_vld;
    t_sample   r_o_sample;

    logic      adv_o, adv_b, adv_a;
    logic      hist_upd;
    t_hist     n_y;
    t_sample   scaled;
    t_sample   n_o_sample;

    // each stage may load when it is empty or its content moves on
    assign adv_o = !r_o_vld || o_out.ready;
    assign adv_b = !r_b_vld || adv_o;
    assign adv_a = !r_a_vld || adv_b;

    assign i_in.ready  = adv_a;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid      = r_o_vld;
    assign o_out.sample_out = r_o_sample;

    // history moves only for filtered samples leaving stage a
    assign hist_upd = r_a_vld && adv_b && !r_coef.bypass;

    bqlp_tap_sum u_tap_sum (
        .i_coef (r_coef),
        .i_x    (r_a_x),
        .i_x1   (r_x1),
        .i_x2   (r_x2),
        .i_y1   (r_y1),
        .i_y2   (r_y2),
        .o_y    (n_y)
    );

    bqlp_out_scale u_out_scale (
        .i_y      (r_b_y),
        .o_sample (scaled)
    );

    assign n_o_sample = r_b_byp ? r_b_x : scaled;

    // config writes, ignored beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.b0     <= RST_B0;
            r_coef.b1     <= RST_B1;
            r_coef.b2     <= RST_B2;
            r_coef.a1     <= RST_A1;
            r_coef.a2     <= RST_A2;
            r_coef.bypass <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_B0:     r_coef.b0     <= i_cfg.data;
                REG_B1:     r_coef.b1     <= i_cfg.data;
                REG_B2:     r_coef.b2     <= i_cfg.data;
                REG_A1:     r_coef.a1     <= i_cfg.data;
                REG_A2:     r_coef.a2     <= i_cfg.data;
                REG_BYPASS: r_coef.bypass <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    // pipeline valids and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
            r_x1    <= '0;
            r_x2    <= '0;
            r_y1    <= '0;
            r_y2    <= '0;
        end else begin
            if (adv_a) begin
                r_a_vld <= i_in.valid;
            end
            if (adv_b) begin
                r_b_vld <= r_a_vld;
            end
            if (adv_o) begin
                r_o_vld <= r_b_vld;
            end
            if (hist_upd) begin
                r_x2 <= r_x1;
                r_x1 <= r_a_x;
                r_y2 <= r_y1;
                r_y1 <= n_y;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv_a && i_in.valid) begin
            r_a_x <= i_in.sample_in;
        end
        if (adv_b && r_a_vld) begin
            r_b_x   <= r_a_x;
            r_b_byp <= r_coef.bypass;
            r_b_y   <= n_y;
        end
        if (adv_o && r_b_vld) begin
            r_o_sample <= n_o_sample;
        end
    end

endmodule

// ===== tb/biquad_lowpass_filter_top_test.sv =====
`timescale 1ns / 1ps

module biquad_lowpass_filter_top_test;
    import bqlp_pkg::*;

    // run shape
    localparam int NUM_PHASES    = 13;
    localparam int PHASE_ITEMS   = 50;
    localparam int HOLD_PHASE    = 4;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 4;    // pipeline is three stages deep

    // register indexes past the last register, writes there must be dropped
    localparam logic [REG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    localparam t_sample SAMPLE_MAX = 16'sh7FFF;
    localparam t_sample SAMPLE_MIN = 16'sh8000;
    localparam t_coef   TAP_MAX    = 24'sh7FFFFF;
    localparam t_coef   TAP_MIN    = 24'sh800000;
    localparam int      TAP_ONE    = 1 << COEF_FRAC_BITS;

    localparam longint HIST_MAX = (longint'(1) <<< (HIST_W - 1)) - 1;
    localparam longint HIST_MIN = -(longint'(1) <<< (HIST_W - 1));
    localparam longint HIST_ONE = longint'(1) <<< HIST_FRAC_BITS;

    localparam t_coef LOWPASS_TAPS [0:4] = '{RST_B0, RST_B1, RST_B2, RST_A1, RST_A2};

    // how a phase picks its five taps
    typedef enum int {
        TAPS_LOWPASS,
        TAPS_UNITY,
        TAPS_FULL,
        TAPS_EXTREME
    } t_tap_mode;

    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_REG
    } t_row_kind;

    // one directed step: either a register write or a sample, with the
    // expected output typed in only where it is obvious
    typedef struct packed {
        t_row_kind                kind;
        logic [REG_IDX_W-1:0]     idx;
        logic [CFG_DATA_W-1:0]    wdata;
        t_sample                  smp;
        logic                     has_exp;
        t_sample                  exp_out;
    } t_row;

    localparam int N_DIRECTED = 42;
    // sample rows carry REG_B0 in the unused index slot
    localparam t_row DIRECTED [0:N_DIRECTED-1] = '{
        // fresh out of reset all history is zero
        '{ROW_SAMPLE, REG_B0, 24'h0, 16'sd0, 1'b1, 16'sd0},
        // reset lowpass driven at full scale both ways
        '{ROW_SAMPLE, REG_B0, 24'h0, SAMPLE_MAX, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, SAMPLE_MAX, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, SAMPLE_MIN, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, SAMPLE_MIN, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, 16'sd1234, 1'b0, 16'sd0},
        // bypass passes samples straight through
        '{ROW_REG, REG_BYPASS, 24'h1, 16'sd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, SAMPLE_MIN, 1'b1, SAMPLE_MIN},
        '{ROW_SAMPLE, REG_B0, 24'h0, SAMPLE_MAX, 1'b1, SAMPLE_MAX},
        '{ROW_SAMPLE, REG_B0, 24'h0, -16'sd1, 1'b1, -16'sd1},
        // only bit 0 counts, so this clears bypass; history must be frozen
        '{ROW_REG, REG_BYPASS, 24'hFFFFFE, 16'sd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, 16'sd0, 1'b0, 16'sd0},
        // writes past the last register do nothing
        '{ROW_REG, IDX_SPARE_LO, 24'h7FFFFF, 16'sd0, 1'b0, 16'sd0},
        '{ROW_REG, IDX_SPARE_HI, 24'h800000, 16'sd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, -16'sd20000, 1'b0, 16'sd0},
        // all taps zero give zero out whatever comes in
        '{ROW_REG, REG_B0, 24'h0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_REG, REG_B1, 24'h0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_REG, REG_B2, 24'h0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_REG, REG_A1, 24'h0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_REG, REG_A2, 24'h0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, SAMPLE_MAX, 1'b1, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, SAMPLE_MIN, 1'b1, 16'sd0},
        // max feedforward, min feedback: history runs away and saturates
        '{ROW_REG, REG_B0, 24'h7FFFFF, 16'sd0, 1'b0, 16'sd0},
        '{ROW_REG, REG_B1, 24'h7FFFFF, 16'sd0, 1'b0, 16'sd0},
        '{ROW_REG, REG_B2, 24'h7FFFFF, 16'sd0, 1'b0, 16'sd0},
        '{ROW_REG, REG_A1, 24'h800000, 16'sd0, 1'b0, 16'sd0},
        '{ROW_REG, REG_A2, 24'h800000, 16'sd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, SAMPLE_MAX, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, SAMPLE_MAX, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, SAMPLE_MAX, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, SAMPLE_MIN, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, SAMPLE_MIN, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, SAMPLE_MIN, 1'b0, 16'sd0},
        // the mirror corner: min feedforward, max feedback
        '{ROW_REG, REG_B0, 24'h800000, 16'sd0, 1'b0, 16'sd0},
        '{ROW_REG, REG_B1, 24'h800000, 16'sd0, 1'b0, 16'sd0},
        '{ROW_REG, REG_B2, 24'h800000, 16'sd0, 1'b0, 16'sd0},
        '{ROW_REG, REG_A1, 24'h7FFFFF, 16'sd0, 1'b0, 16'sd0},
        '{ROW_REG, REG_A2, 24'h7FFFFF, 16'sd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, SAMPLE_MAX, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, SAMPLE_MIN, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, 16'sd12345, 1'b0, 16'sd0},
        '{ROW_SAMPLE, REG_B0, 24'h0, SAMPLE_MIN, 1'b0, 16'sd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    bqlp_in_if  in_bus();
    bqlp_out_if out_bus();
    bqlp_cfg_if cfg_bus();

    biquad_lowpass_filter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    // filter state as the testbench sees it
    t_coef_set coefs;
    t_sample   hist_x1;
    t_sample   hist_x2;
    t_hist     hist_y1;
    t_hist     hist_y2;

    t_sample expected_samples [$];
    int      error_count = 0;
    bit      quiet = 1'b0;       // both sides run without gaps
    bit      hold_req = 1'b0;    // asks the output side for one long stall

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // next output sample; advances the history unless bypassed
    function automatic t_sample filter_sample(input t_sample x_in);
        longint x;
        longint acc;
        longint y;
        longint c;
        if (coefs.bypass)
            return x_in;
        x = x_in;
        // input products sit at Q.35, pushed up to Q.44 to meet the feedback terms
        acc = (longint'($signed(coefs.b0)) * x
               + longint'($signed(coefs.b1)) * longint'(hist_x1)
               + longint'($signed(coefs.b2)) * longint'(hist_x2)) * (longint'(1) <<< IN_ALIGN)
            - longint'($signed(coefs.a1)) * longint'(hist_y1)
            - longint'($signed(coefs.a2)) * longint'(hist_y2);
        y = acc >>> COEF_FRAC_BITS;     // floor
        if (y > HIST_MAX)
            y = HIST_MAX;
        if (y < HIST_MIN)
            y = HIST_MIN;
        hist_x2 = hist_x1;
        hist_x1 = x_in;
        hist_y2 = hist_y1;
        hist_y1 = t_hist'(y);
        // clamp to +/-1.0, then gain with truncation toward zero
        c = y;
        if (c > HIST_ONE)
            c = HIST_ONE;
        if (c < -HIST_ONE)
            c = -HIST_ONE;
        return t_sample'((c * OUT_GAIN) / HIST_ONE);
    endfunction

    function automatic void set_coef_reg(input logic [REG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] wdata);
        case (idx)
            REG_B0:     coefs.b0 = wdata;
            REG_B1:     coefs.b1 = wdata;
            REG_B2:     coefs.b2 = wdata;
            REG_A1:     coefs.a1 = wdata;
            REG_A2:     coefs.a2 = wdata;
            REG_BYPASS: coefs.bypass = wdata[0];
            default:    ;
        endcase
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_coef pick_tap(input t_tap_mode mode, input int k);
        case (mode)
            TAPS_LOWPASS: return LOWPASS_TAPS[k];
            TAPS_UNITY:   return t_coef'(int'($urandom_range(0, 2 * TAP_ONE)) - TAP_ONE);
            TAPS_FULL:    return t_coef'($urandom);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return TAP_MAX;
                    1:       return TAP_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return t_sample'(int'($urandom_range(0, 511)) - 256);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // register writes only once the pipeline has drained
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] wdata);
        in_bus.valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= wdata;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        set_coef_reg(idx, wdata);
    endtask

    // valid stays high after the transaction so the next sample can follow
    // without a bubble; whoever comes next lowers it if needed
    task automatic send_sample(input t_sample smp, input bit has_exp,
                               input t_sample exp_out);
        int      gap;
        t_sample predicted;
        gap = quiet ? 0 : idle_gap();
        if (gap != 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.sample_in <= smp;
        @(posedge i_clk);
        while (!in_bus.ready)
            @(posedge i_clk);
        predicted = filter_sample(smp);
        expected_samples.push_back(has_exp ? exp_out : predicted);
    endtask

    // output side: random ready pattern plus one long stall on request
    initial begin : ready_driver
        int on_len;
        int off_len;
        out_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                // input keeps offering while this stalls, so the pipe fills
                hold_req = 1'b0;
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            on_len = $urandom_range(1, 24);
            out_bus.ready <= 1'b1;
            repeat (on_len) @(posedge i_clk);
            off_len = quiet ? 0 : idle_gap();
            if (off_len != 0) begin
                out_bus.ready <= 1'b0;
                repeat (off_len) @(posedge i_clk);
            end
        end
    end

    // every output transaction is matched against the oldest expectation
    always @(posedge i_clk) begin : out_check
        t_sample want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_samples.size() == 0) begin
                $error("sample_out: expected none, got %0d", out_bus.sample_out);
                error_count++;
            end else begin
                want = expected_samples.pop_front();
                if (out_bus.sample_out !== want) begin
                    $error("sample_out: expected %0d, got %0d", want, out_bus.sample_out);
                    error_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_tap_mode             tap_mode;
        logic [CFG_DATA_W-1:0] wdata;
        coefs   = '{b0: RST_B0, b1: RST_B1, b2: RST_B2, a1: RST_A1, a2: RST_A2,
                    bypass: 1'b0};
        hist_x1 = '0;
        hist_x2 = '0;
        hist_y1 = '0;
        hist_y2 = '0;

        i_rst_n          <= 1'b0;
        in_bus.valid     <= 1'b0;
        in_bus.sample_in <= '0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= '0;
        cfg_bus.data     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED[i].kind == ROW_REG)
                write_reg(DIRECTED[i].idx, DIRECTED[i].wdata);
            else
                send_sample(DIRECTED[i].smp, DIRECTED[i].has_exp, DIRECTED[i].exp_out);
        end

        // random phases, each with its own tap set and bypass setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            quiet    = 1'b0;
            tap_mode = t_tap_mode'($urandom_range(TAPS_LOWPASS, TAPS_EXTREME));
            for (int k = REG_B0; k < REG_BYPASS; k++)
                write_reg(REG_IDX_W'(k), pick_tap(tap_mode, k));
            // bypass now and then, with junk in the upper bits
            wdata    = CFG_DATA_W'($urandom);
            wdata[0] = ($urandom_range(0, 4) == 0);
            write_reg(REG_BYPASS, wdata);
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? IDX_SPARE_HI : IDX_SPARE_LO,
                          CFG_DATA_W'($urandom));

            quiet = (ph == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
            if (ph == HOLD_PHASE)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_sample(), 1'b0, '0);
        end

        in_bus.valid <= 1'b0;
        quiet = 1'b0;
        while (expected_samples.size() != 0)
            @(posedge i_clk);
        // watch a little longer for anything extra
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
